// File: hw/rtl/pcps_pkg.sv
// ----------------------------------------------------------------------------
// pcps_pkg
// Shared types, constants and helpers for the command poll sequencer.
// ----------------------------------------------------------------------------
package pcps_pkg;

   // slot counts and field widths
   localparam int CMD_SLOTS = 5;
   localparam int REQ_SLOTS = 5;
   localparam int SLOT_W    = 3;
   localparam int SEQ_W     = 8;
   localparam int CODE_W    = 3;
   localparam int BYTE_W    = 8;
   localparam int CNT_W     = 4;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   // saturation value of the confirm counters
   localparam logic [CNT_W-1:0] COUNT_MAX = '1;

   // reset value of the confirm threshold
   localparam logic [CNT_W-1:0] THRESHOLD_RESET = 4'd10;

   // register index of the confirm threshold
   localparam logic REG_CONFIRM_THRESHOLD = 1'b0;

   // command slot codes
   localparam logic [SLOT_W-1:0] SLOT_BATTERY = 3'd0;
   localparam logic [SLOT_W-1:0] SLOT_ENGINE  = 3'd1;
   localparam logic [SLOT_W-1:0] SLOT_MANUAL  = 3'd2;
   localparam logic [SLOT_W-1:0] SLOT_THROTTLE = 3'd3;
   localparam logic [SLOT_W-1:0] SLOT_CHECK   = 3'd4;

   // engine code pairs
   localparam logic [CODE_W-1:0] CODE_START_A = 3'b010;
   localparam logic [CODE_W-1:0] CODE_START_B = 3'b011;
   localparam logic [CODE_W-1:0] CODE_STOP_A  = 3'b100;
   localparam logic [CODE_W-1:0] CODE_STOP_B  = 3'b101;

   // frame kinds
   localparam logic FRAME_CMD = 1'b0;
   localparam logic FRAME_REQ = 1'b1;

   // one outgoing frame
   typedef struct packed {
      logic              kind;
      logic [SLOT_W-1:0] slot;
      logic [BYTE_W-1:0] payload;
      logic              last;
   } frame_type;

   // frames of one tick handed to the output buffer
   typedef struct packed {
      logic      load;
      logic      cmd_vld;
      frame_type cmd;
      frame_type req;
   } load_type;

   // next value of a confirm counter: count up on a toggling pair, else clear
   function automatic logic [CNT_W-1:0] pair_count(
      input logic [CNT_W-1:0]  count,
      input logic [CODE_W-1:0] cur,
      input logic [CODE_W-1:0] prev,
      input logic [CODE_W-1:0] a,
      input logic [CODE_W-1:0] b
   );
      logic toggled;
      toggled = ((cur == a) && (prev == b)) || ((cur == b) && (prev == a));
      if (!toggled) begin
         return '0;
      end
      return (count == COUNT_MAX) ? COUNT_MAX : count + 1'b1;
   endfunction

   // round-robin slot advance
   function automatic logic [SLOT_W-1:0] slot_next(
      input logic [SLOT_W-1:0] cur,
      input logic [SLOT_W-1:0] top
   );
      return (cur >= top) ? '0 : cur + 1'b1;
   endfunction

endpackage

// File: hw/rtl/pcps_csr.sv
// ----------------------------------------------------------------------------
// pcps_csr
// Register port holding the engine confirm threshold.
// ----------------------------------------------------------------------------
module pcps_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pcps_pkg::ADDR_W-1:0]   paddr,
   input  logic [pcps_pkg::DATA_W-1:0]   pwdata,
   output logic [pcps_pkg::DATA_W-1:0]   prdata,
   output logic                          pready,
   output logic [pcps_pkg::CNT_W-1:0]    threshold
);

   logic [pcps_pkg::CNT_W-1:0] threshold_ff;
   logic [pcps_pkg::CNT_W-1:0] threshold_in;
   logic                       hit;

   // address decode on paddr[2] only, one register at offset zero
   assign hit    = (paddr[2] == pcps_pkg::REG_CONFIRM_THRESHOLD);
   assign pready = 1'b1;

   // write path
   always_comb begin
      threshold_in = threshold_ff;
      if (psel && penable && pwrite && hit) begin
         threshold_in = pwdata[pcps_pkg::CNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= pcps_pkg::THRESHOLD_RESET;
      end else begin
         threshold_ff <= threshold_in;
      end
   end

   // read path
   assign prdata    = hit ? {{(pcps_pkg::DATA_W-pcps_pkg::CNT_W){1'b0}}, threshold_ff} : '0;
   assign threshold = threshold_ff;

endmodule

// File: hw/rtl/pcps_core.sv
// ----------------------------------------------------------------------------
// pcps_core
// Request register, sequencer state and frame generation for one tick.
// ----------------------------------------------------------------------------
module pcps_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pcps_pkg::SEQ_W-1:0]    req_new_seq,
   input  logic [pcps_pkg::CODE_W-1:0]   req_engine_code,
   input  logic [pcps_pkg::BYTE_W-1:0]   req_battery_level,
   input  logic                          req_manual_mode,
   input  logic [pcps_pkg::BYTE_W-1:0]   req_throttle_pct,
   input  logic                          req_choke_closed,
   input  logic [pcps_pkg::CNT_W-1:0]    threshold,
   input  logic                          load_ok,
   output pcps_pkg::load_type            ld
);

   // request register
   logic                        in_vld_ff, in_vld_in;
   logic [pcps_pkg::SEQ_W-1:0]  in_seq_ff;
   logic [pcps_pkg::CODE_W-1:0] in_code_ff;
   logic [pcps_pkg::BYTE_W-1:0] in_batt_ff;
   logic                        in_manual_ff;
   logic [pcps_pkg::BYTE_W-1:0] in_thr_ff;
   logic                        in_choke_ff;

   // sequencer state
   logic [pcps_pkg::SEQ_W-1:0]  last_seq_ff, last_seq_in;
   logic [pcps_pkg::CODE_W-1:0] cur_code_ff, cur_code_in;
   logic [pcps_pkg::CODE_W-1:0] prev_code_ff, prev_code_in;
   logic [pcps_pkg::BYTE_W-1:0] batt_ff, batt_in;
   logic                        manual_ff, manual_in;
   logic [pcps_pkg::BYTE_W-1:0] thr_ff, thr_in;
   logic                        choke_ff, choke_in;
   logic [pcps_pkg::SLOT_W-1:0] cmd_slot_ff, cmd_slot_in;
   logic [pcps_pkg::SLOT_W-1:0] req_slot_ff, req_slot_in;
   logic                        engine_on_ff, engine_on_in;
   logic [pcps_pkg::CNT_W-1:0]  start_cnt_ff, start_cnt_in;
   logic [pcps_pkg::CNT_W-1:0]  stop_cnt_ff, stop_cnt_in;

   logic                        move;
   logic                        take;
   logic                        new_cmds;
   logic [pcps_pkg::CNT_W-1:0]  start_upd;
   logic [pcps_pkg::CNT_W-1:0]  stop_upd;

   // handshake on the request side
   assign move      = in_vld_ff && load_ok;
   assign req_stall = in_vld_ff && !load_ok;
   assign take      = req_valid && !req_stall;
   assign in_vld_in = take || (in_vld_ff && !move);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else begin
         in_vld_ff <= in_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_seq_ff    <= req_new_seq;
         in_code_ff   <= req_engine_code;
         in_batt_ff   <= req_battery_level;
         in_manual_ff <= req_manual_mode;
         in_thr_ff    <= req_throttle_pct;
         in_choke_ff  <= req_choke_closed;
      end
   end

   // command latch on a new sequence number
   assign new_cmds     = (in_seq_ff != last_seq_ff);
   assign last_seq_in  = new_cmds ? in_seq_ff    : last_seq_ff;
   assign cur_code_in  = new_cmds ? in_code_ff   : cur_code_ff;
   assign prev_code_in = new_cmds ? cur_code_ff  : prev_code_ff;
   assign batt_in      = new_cmds ? in_batt_ff   : batt_ff;
   assign manual_in    = new_cmds ? in_manual_ff : manual_ff;
   assign thr_in       = new_cmds ? in_thr_ff    : thr_ff;
   assign choke_in     = new_cmds ? in_choke_ff  : choke_ff;

   // pair counter updates with the freshly latched codes
   assign start_upd = pcps_pkg::pair_count(start_cnt_ff, cur_code_in, prev_code_in,
                                           pcps_pkg::CODE_START_A, pcps_pkg::CODE_START_B);
   assign stop_upd  = pcps_pkg::pair_count(stop_cnt_ff, cur_code_in, prev_code_in,
                                           pcps_pkg::CODE_STOP_A, pcps_pkg::CODE_STOP_B);

   // command slot service, engine on/off control and the status request frame
   always_comb begin
      engine_on_in   = engine_on_ff;
      start_cnt_in   = start_cnt_ff;
      stop_cnt_in    = stop_cnt_ff;
      ld.load        = move;
      ld.cmd_vld     = 1'b1;
      ld.cmd.kind    = pcps_pkg::FRAME_CMD;
      ld.cmd.slot    = cmd_slot_ff;
      ld.cmd.payload = '0;
      ld.cmd.last    = 1'b0;
      ld.req.kind    = pcps_pkg::FRAME_REQ;
      ld.req.slot    = req_slot_ff;
      ld.req.payload = '0;
      ld.req.last    = 1'b1;
      case (cmd_slot_ff)
         pcps_pkg::SLOT_BATTERY: begin
            ld.cmd.payload = batt_in;
         end
         pcps_pkg::SLOT_ENGINE: begin
            ld.cmd_vld = 1'b0;
            if (!engine_on_ff) begin
               if (start_cnt_ff >= threshold) begin
                  engine_on_in   = 1'b1;
                  start_cnt_in   = '0;
                  stop_cnt_in    = stop_upd;
                  ld.cmd_vld     = 1'b1;
                  ld.cmd.payload = 8'd1;
               end else begin
                  start_cnt_in = start_upd;
               end
            end else begin
               if (stop_cnt_ff >= threshold) begin
                  engine_on_in   = 1'b0;
                  stop_cnt_in    = '0;
                  start_cnt_in   = start_upd;
                  ld.cmd_vld     = 1'b1;
                  ld.cmd.payload = 8'd0;
               end else begin
                  stop_cnt_in = stop_upd;
               end
            end
         end
         pcps_pkg::SLOT_MANUAL: begin
            ld.cmd.payload = {7'd0, manual_in};
         end
         pcps_pkg::SLOT_THROTTLE: begin
            ld.cmd.payload = thr_in;
         end
         pcps_pkg::SLOT_CHECK: begin
            ld.cmd.payload = {7'd0, choke_in};
         end
         default: begin
            ld.cmd_vld = 1'b0;
         end
      endcase
   end

   // slot advance
   assign cmd_slot_in = pcps_pkg::slot_next(cmd_slot_ff,
                                            pcps_pkg::SLOT_W'(pcps_pkg::CMD_SLOTS - 1));
   assign req_slot_in = pcps_pkg::slot_next(req_slot_ff,
                                            pcps_pkg::SLOT_W'(pcps_pkg::REQ_SLOTS - 1));

   // state registers, updated once per tick
   always_ff @(posedge clock) begin
      if (reset) begin
         last_seq_ff  <= '0;
         cur_code_ff  <= '0;
         prev_code_ff <= '0;
         batt_ff      <= '0;
         manual_ff    <= 1'b0;
         thr_ff       <= '0;
         choke_ff     <= 1'b0;
         cmd_slot_ff  <= pcps_pkg::SLOT_BATTERY;
         req_slot_ff  <= '0;
         engine_on_ff <= 1'b0;
         start_cnt_ff <= '0;
         stop_cnt_ff  <= '0;
      end else if (move) begin
         last_seq_ff  <= last_seq_in;
         cur_code_ff  <= cur_code_in;
         prev_code_ff <= prev_code_in;
         batt_ff      <= batt_in;
         manual_ff    <= manual_in;
         thr_ff       <= thr_in;
         choke_ff     <= choke_in;
         cmd_slot_ff  <= cmd_slot_in;
         req_slot_ff  <= req_slot_in;
         engine_on_ff <= engine_on_in;
         start_cnt_ff <= start_cnt_in;
         stop_cnt_ff  <= stop_cnt_in;
      end
   end

endmodule

// File: hw/rtl/pcps_obuf.sv
// ----------------------------------------------------------------------------
// pcps_obuf
// Result register holding the frames of one tick, sent one per cycle unless rsp_stall is high.
// ----------------------------------------------------------------------------
module pcps_obuf (
   input  logic                          clock,
   input  logic                          reset,
   input  pcps_pkg::load_type            ld,
   output logic                          load_ok,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_frame_kind,
   output logic [pcps_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [pcps_pkg::BYTE_W-1:0]   rsp_payload,
   output logic                          rsp_last
);

   logic                cmd_vld_ff, cmd_vld_in;
   logic                req_vld_ff, req_vld_in;
   pcps_pkg::frame_type cmd_ff;
   pcps_pkg::frame_type req_ff;
   pcps_pkg::frame_type head;
   logic                send;

   // buffer may reload once the request frame is leaving or gone
   assign send    = rsp_valid && !rsp_stall;
   assign load_ok = !cmd_vld_ff && (!req_vld_ff || send);

   // valid bits: command frame goes first, request frame last
   always_comb begin
      cmd_vld_in = cmd_vld_ff;
      req_vld_in = req_vld_ff;
      if (ld.load) begin
         cmd_vld_in = ld.cmd_vld;
         req_vld_in = 1'b1;
      end else if (send) begin
         if (cmd_vld_ff) begin
            cmd_vld_in = 1'b0;
         end else begin
            req_vld_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cmd_vld_ff <= 1'b0;
         req_vld_ff <= 1'b0;
      end else begin
         cmd_vld_ff <= cmd_vld_in;
         req_vld_ff <= req_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ld.load) begin
         cmd_ff <= ld.cmd;
         req_ff <= ld.req;
      end
   end

   // head of buffer drives the result port
   assign head           = cmd_vld_ff ? cmd_ff : req_ff;
   assign rsp_valid      = cmd_vld_ff || req_vld_ff;
   assign rsp_frame_kind = head.kind;
   assign rsp_slot       = head.slot;
   assign rsp_payload    = head.payload;
   assign rsp_last       = head.last;

endmodule

// File: hw/rtl/pmu_command_poll_sequencer_unit.sv
// ----------------------------------------------------------------------------
// pmu_command_poll_sequencer_unit
// Per-tick command slot poller with engine start/stop confirmation.
// ----------------------------------------------------------------------------
//  port group | direction | handshake          | carries
//  req_*      | in        | req_valid/stall    | one scheduler tick with commands
//  rsp_*      | out       | rsp_valid/stall    | one frame (command or status request)
//  p*         | in/out    | psel/penable/ready | confirm threshold register
//
//  a tick is taken into the request register, then, once the result register
//  can reload, updates the sequencer state and loads one or two frames there
//  frames leave one per cycle while rsp_stall is low; a tick carries a command
//  frame and the status request, or only the status request
//  the next tick is taken while the last frame of the previous one waits
//  reset clears the valid bits and the sequencer state; the threshold resets to ten
//  a stall on the result side holds the frames and then the request register
// ----------------------------------------------------------------------------
module pmu_command_poll_sequencer_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [pcps_pkg::SEQ_W-1:0]    req_new_seq,
   input  logic [pcps_pkg::CODE_W-1:0]   req_engine_code,
   input  logic [pcps_pkg::BYTE_W-1:0]   req_battery_level,
   input  logic                          req_manual_mode,
   input  logic [pcps_pkg::BYTE_W-1:0]   req_throttle_pct,
   input  logic                          req_choke_closed,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_frame_kind,
   output logic [pcps_pkg::SLOT_W-1:0]   rsp_slot,
   output logic [pcps_pkg::BYTE_W-1:0]   rsp_payload,
   output logic                          rsp_last,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [pcps_pkg::ADDR_W-1:0]   paddr,
   input  logic [pcps_pkg::DATA_W-1:0]   pwdata,
   output logic [pcps_pkg::DATA_W-1:0]   prdata,
   output logic                          pready
);

   logic [pcps_pkg::CNT_W-1:0] threshold;
   logic                       load_ok;
   pcps_pkg::load_type         ld;

   // configuration register
   pcps_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .threshold (threshold)
   );

   // request register and sequencer
   pcps_core u_core (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_new_seq       (req_new_seq),
      .req_engine_code   (req_engine_code),
      .req_battery_level (req_battery_level),
      .req_manual_mode   (req_manual_mode),
      .req_throttle_pct  (req_throttle_pct),
      .req_choke_closed  (req_choke_closed),
      .threshold         (threshold),
      .load_ok           (load_ok),
      .ld                (ld)
   );

   // result register
   pcps_obuf u_obuf (
      .clock          (clock),
      .reset          (reset),
      .ld             (ld),
      .load_ok        (load_ok),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_frame_kind (rsp_frame_kind),
      .rsp_slot       (rsp_slot),
      .rsp_payload    (rsp_payload),
      .rsp_last       (rsp_last)
   );

endmodule
